/* rtl/i2c_eeprom_read_master_macros.svh */
// assertion macros for the i2c eeprom read master
// no dependencies; expects clk and rst_n in the including module
`ifndef I2C_EEPROM_READ_MASTER_MACROS_SVH
`define I2C_EEPROM_READ_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// check that is suspended while reset is asserted
`define ERM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define ERM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ERM_ASSERT(lbl, prop, msg)

`define ERM_ASSERT_RST(lbl, prop, msg)

`endif

`endif

/* rtl/i2c_eer_pkg.sv */
// types and constants for the i2c eeprom read master
// no dependencies
package i2c_eer_pkg;

  // one tick of input
  typedef struct packed {
    logic go;
    logic sda_in;
  } in_t;

  // one tick of line levels and status
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [15:0] byte_address;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  error_code;
  } out_t;

  // sequencer phases
  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_START   = 11'b000_0000_0010,
    PH_SEND_DW = 11'b000_0000_0100,
    PH_SEND_AH = 11'b000_0000_1000,
    PH_SEND_AL = 11'b000_0001_0000,
    PH_SEND_DR = 11'b000_0010_0000,
    PH_RS_A    = 11'b000_0100_0000,
    PH_RS_B    = 11'b000_1000_0000,
    PH_RECV    = 11'b001_0000_0000,
    PH_STOP    = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_t;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_DEV_WR  = 3'd1;
  localparam logic [2:0] ERR_ADDR_HI = 3'd2;
  localparam logic [2:0] ERR_ADDR_LO = 3'd3;
  localparam logic [2:0] ERR_DEV_RD  = 3'd4;

  // register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_START_ADDRESS  = 2'd1;
  localparam logic [1:0] CFG_READ_LENGTH    = 2'd2;
  localparam logic [1:0] CFG_QUARTER_TICKS  = 2'd3;

  // register reset values
  localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'h50;
  localparam logic [15:0] RST_START_ADDRESS  = 16'h0000;
  localparam logic [16:0] RST_READ_LENGTH    = 17'h00200;
  localparam logic [15:0] RST_QUARTER_TICKS  = 16'd250;

endpackage

/* rtl/i2c_eeprom_read_master.sv */
// i2c master doing a sequential random read from a 16-bit addressed eeprom
// depends on i2c_eer_pkg and i2c_eeprom_read_master_macros.svh
// output: the result for a tick is captured in the output register when the tick is transferred
// throughput: one tick per cycle while out_ready does not stall the output, set by a single state update pass per tick
// reset: synchronous active-low rst_n returns the sequencer to idle, clears the
//   output valid flag and loads the register defaults
`include "i2c_eeprom_read_master_macros.svh"

module i2c_eeprom_read_master #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2c_eer_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output i2c_eer_pkg::out_t  out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import i2c_eer_pkg::*;

  localparam logic [15:0] AddrMask = 16'((17'd1 << ADDR_WIDTH) - 17'd1);
  localparam bit          SendHigh = (ADDR_WIDTH > 8);

  // configuration registers
  logic [6:0]  device_address_r;
  logic [15:0] start_address_r;
  logic [16:0] read_length_r;
  logic [15:0] quarter_ticks_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [2:0]  quarter_r, quarter_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [16:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [2:0]  last_error_r, last_error_nxt;

  // output register
  logic out_valid_r;
  out_t out_data_r;
  out_t res;

  // working values of the update pass
  logic        in_fire;
  logic        is_send;
  logic [15:0] qt;
  logic [16:0] tc_inc;
  logic [3:0]  q_inc;
  logic [3:0]  seg_q;
  logic [15:0] addr_m;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign addr_m    = start_address_r & AddrMask;
  assign qt        = (quarter_ticks_r == 16'd0) ? 16'd1 : quarter_ticks_r;

  // one tick: take go, form the line levels, then advance the timing
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    quarter_nxt    = quarter_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    cur_addr_nxt   = cur_addr_r;
    last_error_nxt = last_error_r;
    tc_inc         = '0;
    q_inc          = '0;
    seg_q          = 4'd4;

    // go is taken only from idle
    if (phase_r == PH_IDLE && in_data.go) begin
      phase_nxt      = PH_START;
      tick_count_nxt = '0;
      quarter_nxt    = '0;
      bit_index_nxt  = '0;
      shift_nxt      = '0;
      bytes_left_nxt = read_length_r;
      cur_addr_nxt   = start_address_r;
      last_error_nxt = ERR_NONE;
    end

    is_send = (phase_nxt == PH_SEND_DW) || (phase_nxt == PH_SEND_AH) ||
              (phase_nxt == PH_SEND_AL) || (phase_nxt == PH_SEND_DR);

    // line levels and sampling for this tick
    res              = '0;
    res.scl_out      = 1'b1;
    res.sda_out      = 1'b1;
    res.sda_drive    = 1'b1;
    res.busy_res     = 1'b1;
    unique case (phase_nxt)
      PH_IDLE: begin
        res.busy_res = 1'b0;
      end
      PH_DONE: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
      end
      PH_START, PH_RS_B: begin
        res.sda_out = 1'b0;
      end
      PH_SEND_DW, PH_SEND_AH, PH_SEND_AL, PH_SEND_DR: begin
        if (!bit_index_nxt[3]) begin
          res.scl_out = quarter_nxt[1] || quarter_nxt[2];
          res.sda_out = shift_nxt[7];
        end else begin
          res.scl_out   = (quarter_nxt == 3'd2) || (quarter_nxt == 3'd3);
          res.sda_drive = (quarter_nxt == 3'd5);
          if (quarter_nxt == 3'd3 && tick_count_nxt == 16'd0) begin
            shift_nxt = {7'd0, in_data.sda_in};
          end
        end
      end
      PH_RS_A: begin
        res.scl_out = quarter_nxt[2];
      end
      PH_RECV: begin
        res.scl_out = quarter_nxt[1] || quarter_nxt[2];
        if (!bit_index_nxt[3]) begin
          res.sda_drive = 1'b0;
          if (quarter_nxt == 3'd3 && tick_count_nxt == 16'd0) begin
            shift_nxt = {shift_nxt[6:0], in_data.sda_in};
            if (bit_index_nxt == 4'd7) begin
              res.byte_valid   = 1'b1;
              res.byte_value   = shift_nxt;
              res.byte_address = cur_addr_nxt;
            end
          end
        end else begin
          res.sda_out = (bytes_left_nxt > 17'd1) ? 1'b0 : 1'b1;
        end
      end
      PH_STOP: begin
        res.scl_out = quarter_nxt[2];
        res.sda_out = 1'b0;
      end
      default: ;
    endcase
    res.error_code = last_error_nxt;

    // quarter length of the current segment
    if (phase_nxt == PH_RS_A || phase_nxt == PH_STOP) begin
      seg_q = 4'd8;
    end else if (is_send && bit_index_nxt[3]) begin
      seg_q = 4'd6;
    end

    // timing advance and segment end
    if (phase_nxt == PH_DONE) begin
      phase_nxt = PH_IDLE;
    end else if (phase_nxt != PH_IDLE) begin
      tc_inc = {1'b0, tick_count_nxt} + 17'd1;
      if (tc_inc >= {1'b0, qt}) begin
        tick_count_nxt = '0;
        q_inc = {1'b0, quarter_nxt} + 4'd1;
        if (q_inc >= seg_q) begin
          quarter_nxt = '0;
          unique case (phase_nxt)
            PH_START: begin
              phase_nxt     = PH_SEND_DW;
              bit_index_nxt = '0;
              shift_nxt     = {device_address_r, 1'b0};
            end
            PH_SEND_DW, PH_SEND_AH, PH_SEND_AL, PH_SEND_DR: begin
              priority if (!bit_index_nxt[3]) begin
                shift_nxt     = {shift_nxt[6:0], 1'b0};
                bit_index_nxt = bit_index_nxt + 4'd1;
              end else if (shift_nxt[0]) begin
                // device nak: record which byte and stop
                priority if (phase_nxt == PH_SEND_DW) begin
                  last_error_nxt = ERR_DEV_WR;
                end else if (phase_nxt == PH_SEND_AH) begin
                  last_error_nxt = ERR_ADDR_HI;
                end else if (phase_nxt == PH_SEND_AL) begin
                  last_error_nxt = ERR_ADDR_LO;
                end else begin
                  last_error_nxt = ERR_DEV_RD;
                end
                phase_nxt = PH_STOP;
              end else if (phase_nxt == PH_SEND_DW) begin
                bit_index_nxt = '0;
                if (SendHigh) begin
                  phase_nxt = PH_SEND_AH;
                  shift_nxt = addr_m[15:8];
                end else begin
                  phase_nxt = PH_SEND_AL;
                  shift_nxt = addr_m[7:0];
                end
              end else if (phase_nxt == PH_SEND_AH) begin
                phase_nxt     = PH_SEND_AL;
                bit_index_nxt = '0;
                shift_nxt     = addr_m[7:0];
              end else if (phase_nxt == PH_SEND_AL) begin
                phase_nxt = PH_RS_A;
              end else if (bytes_left_nxt == 17'd0) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt     = PH_RECV;
                bit_index_nxt = '0;
                shift_nxt     = '0;
              end
            end
            PH_RS_A: begin
              phase_nxt = PH_RS_B;
            end
            PH_RS_B: begin
              phase_nxt     = PH_SEND_DR;
              bit_index_nxt = '0;
              shift_nxt     = {device_address_r, 1'b1};
            end
            PH_RECV: begin
              if (!bit_index_nxt[3]) begin
                bit_index_nxt = bit_index_nxt + 4'd1;
              end else begin
                bytes_left_nxt = bytes_left_nxt - 17'd1;
                cur_addr_nxt   = cur_addr_nxt + 16'd1;
                if (bytes_left_nxt == 17'd0) begin
                  phase_nxt = PH_STOP;
                end else begin
                  bit_index_nxt = '0;
                  shift_nxt     = '0;
                end
              end
            end
            PH_STOP: begin
              phase_nxt = PH_DONE;
            end
            default: ;
          endcase
        end else begin
          quarter_nxt = q_inc[2:0];
        end
      end else begin
        tick_count_nxt = tc_inc[15:0];
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= RST_DEVICE_ADDRESS;
      start_address_r  <= RST_START_ADDRESS;
      read_length_r    <= RST_READ_LENGTH;
      quarter_ticks_r  <= RST_QUARTER_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address_r <= cfg_data[6:0];
        CFG_START_ADDRESS:  start_address_r  <= cfg_data[15:0];
        CFG_READ_LENGTH:    read_length_r    <= cfg_data;
        CFG_QUARTER_TICKS:  quarter_ticks_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer state moves once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      quarter_r    <= '0;
      bit_index_r  <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      cur_addr_r   <= '0;
      last_error_r <= ERR_NONE;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      quarter_r    <= quarter_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      cur_addr_r   <= cur_addr_nxt;
      last_error_r <= last_error_nxt;
    end
  end

  // output register, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  // checks
  `ERM_ASSERT_RST(a_reset_empties_output, !rst_n |=> !out_valid_r, "output valid after reset")
  `ERM_ASSERT(a_busy_done_excl, out_valid_r |-> !(out_data_r.busy_res && out_data_r.done_res), "busy and done together")
  `ERM_ASSERT(a_release_high, (out_valid_r && !out_data_r.sda_drive) |-> out_data_r.sda_out, "sda low while released")
  `ERM_ASSERT(a_done_to_idle, (in_fire && phase_r == PH_DONE) |=> (phase_r == PH_IDLE), "done tick not followed by idle")
  `ERM_ASSERT(a_idle_tick_zero, (phase_r == PH_IDLE) |-> (tick_count_r == 16'd0), "tick count running in idle")

endmodule
